>>> design/tbs_pkg.sv
// tbs_pkg: shared types, defaults and state codes of the token bucket scheduler
// used by the controller, the datapath, the top level and the checker

package tbs_pkg;

  localparam int VMS_DEF          = 8;
  localparam int MAX_TOKENS_DEF   = 1024;
  localparam int SWITCH_TICKS_DEF = 8;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_BURST = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  cur_vm;
    logic [7:0]  active_mask;
    logic [7:0]  running_mask;
    logic [2:0]  vm_index;
    logic [15:0] burst_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  next_vm;
    logic [15:0] switch_count;
    logic        reschedule;
    logic [15:0] pool_tokens;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BURST,
    S_TICK,
    S_SEARCH,
    S_REFCHK,
    S_REFILL,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic burst_wr;
    logic tick;
    logic search_step;
    logic refchk;
    logic refill_step;
    logic load_out;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_burst;
    logic sw_zero;
    logic search_done;
    logic pool_full;
    logic refill_last;
    logic rsp_free;
  } sts_t;

endpackage

>>> design/vm_token_bucket_scheduler.sv
// vm_token_bucket_scheduler: top level of the token bucket scheduler
// depends on tbs_pkg, tbs_ctrl and tbs_datapath
//
// One word in, one word out; words are handled one at a time. A burst size
// write passes the idle, tick, burst and finish states; a tick that neither
// searches nor refills passes idle, tick, refill check and finish. A tick
// also enters the search state when the switch counter runs out (the circular
// search visits one VM a cycle), and the refill state when the pool is full
// (the refill walks one VM a cycle). The next word is accepted while a result
// still waits in the output register; its own result then waits in the finish
// state until that register frees.

module vm_token_bucket_scheduler #(
  parameter int VMS          = tbs_pkg::VMS_DEF,
  parameter int MAX_TOKENS   = tbs_pkg::MAX_TOKENS_DEF,
  parameter int SWITCH_TICKS = tbs_pkg::SWITCH_TICKS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tbs_pkg::req_t req_word,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output tbs_pkg::rsp_t rsp_word
);
  import tbs_pkg::*;

  ctl_t ctl;
  sts_t sts;

  tbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  tbs_datapath #(
    .VMS          (VMS),
    .MAX_TOKENS   (MAX_TOKENS),
    .SWITCH_TICKS (SWITCH_TICKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_word  (req_word),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp_word  (rsp_word),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

>>> design/tbs_ctrl.sv
// tbs_ctrl: sequencer of the token bucket scheduler
// depends on tbs_pkg for the state, command and status types

module tbs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tbs_pkg::sts_t sts,
  output tbs_pkg::ctl_t ctl
);
  import tbs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_TICK;
        end
      end
      S_TICK: begin
        if (sts.is_burst) begin
          state_next = S_BURST;
        end else begin
          ctl.tick   = 1'b1;
          state_next = sts.sw_zero ? S_SEARCH : S_REFCHK;
        end
      end
      S_BURST: begin
        ctl.burst_wr = 1'b1;
        state_next   = S_FINISH;
      end
      S_SEARCH: begin
        ctl.search_step = 1'b1;
        if (sts.search_done) begin
          state_next = S_REFCHK;
        end
      end
      S_REFCHK: begin
        ctl.refchk = 1'b1;
        state_next = sts.pool_full ? S_REFILL : S_FINISH;
      end
      S_REFILL: begin
        ctl.refill_step = 1'b1;
        if (sts.refill_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.rsp_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/tbs_datapath.sv
// tbs_datapath: token counts, burst sizes, choice, switch counter and result register
// depends on tbs_pkg; driven by tbs_ctrl commands

module tbs_datapath #(
  parameter int VMS          = tbs_pkg::VMS_DEF,
  parameter int MAX_TOKENS   = tbs_pkg::MAX_TOKENS_DEF,
  parameter int SWITCH_TICKS = tbs_pkg::SWITCH_TICKS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  tbs_pkg::req_t req_word,
  input  logic          rsp_ready,
  output logic          rsp_valid,
  output tbs_pkg::rsp_t rsp_word,
  input  tbs_pkg::ctl_t ctl,
  output tbs_pkg::sts_t sts
);
  import tbs_pkg::*;

  localparam int VW = (VMS > 2) ? $clog2(VMS) : 1;
  localparam int CW = (VW > 3) ? VW : 3;
  localparam logic [VW-1:0] LAST = VW'(VMS - 1);
  localparam logic [15:0] ST = 16'(SWITCH_TICKS);
  localparam logic [15:0] MT = 16'(MAX_TOKENS);

  req_t          item;
  logic [15:0]   tok   [VMS];
  logic [15:0]   burst [VMS];
  logic [15:0]   pool;
  logic [VW-1:0] chosen;
  logic [15:0]   sw;
  logic [VW-1:0] pos;
  logic [VW-1:0] step;
  logic [7:0]    cand;
  logic [VW-1:0] ridx;
  logic          resched;

  logic          run_ok;
  logic [VW-1:0] run_idx;
  logic [VW-1:0] pos_next;
  logic [VW-1:0] rd_addr;
  logic [15:0]   rd_tok;
  logic [15:0]   rd_burst;
  logic          tick_take;
  logic [15:0]   sw_after;
  logic          search_end;
  logic          pos_in;
  logic          hit;
  logic          ref_sel;

  always_comb begin
    run_ok     = item.cur_vm < VMS;
    run_idx    = VW'(item.cur_vm);
    pos_next   = (pos >= LAST) ? VW'(1) : pos + VW'(1);
    rd_addr    = ctl.tick ? run_idx : pos_next;
    rd_tok     = tok[rd_addr];
    rd_burst   = burst[ridx];
    tick_take  = run_ok && (item.cur_vm != 3'd0) && (rd_tok != 16'd0);
    sw_after   = ((CW'(item.cur_vm) == CW'(chosen)) && (sw != 16'd0)) ? sw - 16'd1 : sw;
    search_end = (cand == 8'd0) || (step == LAST);
    pos_in     = pos_next < 8;
    hit        = !search_end && pos_in && cand[3'(pos_next)] && (rd_tok != 16'd0);
    ref_sel    = (ridx < 8) && item.running_mask[3'(ridx)];

    sts.is_burst    = item.req_type == REQ_BURST;
    sts.sw_zero     = sw_after == 16'd0;
    sts.search_done = search_end || hit;
    sts.pool_full   = pool == MT;
    sts.refill_last = ridx == LAST;
    sts.rsp_free    = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      item <= req_word;
    end
    if (ctl.tick) begin
      pos  <= chosen;
      step <= '0;
      cand <= item.active_mask & ~8'd1 & ~(8'd1 << chosen);
      ridx <= VW'(1);
    end
    if (ctl.search_step && !search_end && !hit) begin
      if (pos_in) begin
        cand[3'(pos_next)] <= 1'b0;
      end
      pos  <= pos_next;
      step <= step + VW'(1);
    end
    if (ctl.refill_step && !sts.refill_last) begin
      ridx <= ridx + VW'(1);
    end
    if (ctl.load_out) begin
      rsp_word.next_vm      <= 3'(chosen);
      rsp_word.switch_count <= sw;
      rsp_word.reschedule   <= resched;
      rsp_word.pool_tokens  <= pool;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VMS; i++) begin
        tok[i]   <= '0;
        burst[i] <= '0;
      end
      pool      <= MT;
      chosen    <= '0;
      sw        <= '0;
      resched   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.burst_wr) begin
        if (item.vm_index < VMS) begin
          burst[VW'(item.vm_index)] <= item.burst_value;
        end
        resched <= 1'b0;
      end
      if (ctl.tick) begin
        if (tick_take) begin
          tok[run_idx] <= rd_tok - 16'd1;
          if (pool != 16'hFFFF) begin
            pool <= pool + 16'd1;
          end
        end
        sw      <= sw_after;
        resched <= sw_after == 16'd0;
      end
      if (ctl.search_step) begin
        if (search_end) begin
          chosen <= '0;
          sw     <= ST;
        end else if (hit) begin
          chosen <= pos_next;
          sw     <= (rd_tok > ST) ? ST : rd_tok;
        end
      end
      if (ctl.refchk && sts.pool_full) begin
        resched <= 1'b1;
      end
      if (ctl.refill_step && ref_sel) begin
        tok[ridx] <= rd_burst;
        pool      <= (pool > rd_burst) ? pool - rd_burst : 16'd0;
      end
      if (ctl.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/tbs_checker.sv
// tbs_checker: port level assertions for vm_token_bucket_scheduler
// depends on tbs_pkg; attached to the top level by the bind below

module tbs_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input tbs_pkg::req_t req_word,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input tbs_pkg::rsp_t rsp_word
);
  import tbs_pkg::*;

  // one word in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("word accepted while previous word still in work");

  // a rescheduling result always leaves a nonzero switch count
  a_resched_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.reschedule |-> rsp_word.switch_count != 16'd0)
    else $error("reschedule with zero switch count");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
    else $error("result word dropped or changed while stalled");

  a_rsp_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind vm_token_bucket_scheduler tbs_checker u_tbs_checker (.*);

>>> dv/tb_vm_token_bucket_scheduler.sv
// tb_vm_token_bucket_scheduler: self-checking bench for the token bucket scheduler
// drives tick and burst words, predicts every result word and checks it field by field
// depends on tbs_pkg and vm_token_bucket_scheduler

module tb_vm_token_bucket_scheduler;
  import tbs_pkg::*;

  localparam int VMS             = VMS_DEF;
  localparam int MAX_TOKENS      = MAX_TOKENS_DEF;
  localparam int SWITCH_TICKS    = SWITCH_TICKS_DEF;
  localparam int ITEMS_PER_PHASE = 360;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 4 * VMS;
  localparam int CYCLE_LIMIT     = 6_000_000;
  localparam int SMALL_BURST     = 24;
  localparam int DIR_ROWS        = 25;

  typedef struct {
    req_t word;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_word = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_word;

  // predicted scheduler state
  logic [15:0] pred_tok [VMS];
  logic [15:0] vm_burst [VMS];
  logic [2:0]  pick_vm;
  logic [15:0] ticks_left;

  rsp_t        pending_rsp [$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  bit          hold_req = 1'b0;
  int          trim_vm = 0;
  int unsigned cycle_cnt = 0;
  dir_row_t    dir_rows [DIR_ROWS];

  vm_token_bucket_scheduler DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  function automatic req_t mk_tick(int run, logic [7:0] act, logic [7:0] rm);
    req_t w;
    w = '0;
    w.req_type     = REQ_TICK;
    w.cur_vm       = 3'(run);
    w.active_mask  = act;
    w.running_mask = rm;
    return w;
  endfunction

  function automatic req_t mk_burst(int idx, logic [15:0] val);
    req_t w;
    w = '0;
    w.req_type    = REQ_BURST;
    w.vm_index    = 3'(idx);
    w.burst_value = val;
    return w;
  endfunction

  function automatic rsp_t mk_rsp(int nv, int sc, logic rs, int pt);
    rsp_t r;
    r.next_vm      = 3'(nv);
    r.switch_count = 16'(sc);
    r.reschedule   = rs;
    r.pool_tokens  = 16'(pt);
    return r;
  endfunction

  function automatic rsp_t sched_step(req_t w);
    rsp_t       r;
    logic [7:0] cand;
    int         pos;
    bit         found;
    r = '0;
    if (w.req_type == REQ_BURST) begin
      vm_burst[w.vm_index] = w.burst_value;
    end else begin
      if (pred_tok[w.cur_vm] != 0) begin
        pred_tok[w.cur_vm] = pred_tok[w.cur_vm] - 1;
        if (pred_tok[0] != 16'hFFFF) pred_tok[0] = pred_tok[0] + 1;
      end
      if (w.cur_vm == pick_vm && ticks_left != 0) ticks_left = ticks_left - 1;
      if (ticks_left == 0) begin
        cand = w.active_mask & ~8'h01;
        cand[pick_vm] = 1'b0;
        pos = pick_vm;
        found = 1'b0;
        // circular walk over VMs 1..VMS-1 starting after the current choice
        for (int s = 0; s < VMS - 1 && cand != 0 && !found; s++) begin
          pos = (pos >= VMS - 1) ? 1 : pos + 1;
          if (cand[pos]) begin
            if (pred_tok[pos] != 0) begin
              pick_vm = 3'(pos);
              ticks_left = (pred_tok[pos] > SWITCH_TICKS) ? 16'(SWITCH_TICKS) : pred_tok[pos];
              found = 1'b1;
            end
            cand[pos] = 1'b0;
          end
        end
        if (!found) begin
          pick_vm = '0;
          ticks_left = 16'(SWITCH_TICKS);
        end
        r.reschedule = 1'b1;
      end
      if (pred_tok[0] == MAX_TOKENS) begin
        for (int i = 1; i < VMS; i++) begin
          if (w.running_mask[i]) begin
            pred_tok[i] = vm_burst[i];
            pred_tok[0] = (pred_tok[0] > pred_tok[i]) ? pred_tok[0] - pred_tok[i] : '0;
          end
        end
        r.reschedule = 1'b1;
      end
    end
    r.next_vm      = pick_vm;
    r.switch_count = ticks_left;
    r.pool_tokens  = pred_tok[0];
    return r;
  endfunction

  // random word steered so the pool keeps returning to full and refilling
  function automatic req_t pick_req();
    req_t w;
    int   holders [$];
    int   funded [$];
    int   after;
    w.req_type     = REQ_TICK;
    w.cur_vm       = 3'($urandom_range(7));
    w.active_mask  = 8'($urandom_range(255));
    w.running_mask = 8'($urandom_range(255));
    w.vm_index     = 3'($urandom_range(7));
    w.burst_value  = 16'($urandom_range(16'hFFFF));
    for (int i = 1; i < VMS; i++) begin
      if (pred_tok[i] != 0) holders.push_back(i);
      if (vm_burst[i] != 0) funded.push_back(i);
    end
    if (trim_vm != 0) begin
      w.req_type    = REQ_BURST;
      w.vm_index    = 3'(trim_vm);
      w.burst_value = 16'($urandom_range(SMALL_BURST, 1));
      trim_vm = 0;
      return w;
    end
    if ($urandom_range(99) < 8 || (pred_tok[0] == MAX_TOKENS && funded.size() == 0)) begin
      w.req_type = REQ_BURST;
      case ($urandom_range(19))
        0:       w.burst_value = '0;
        1, 2:    ;
        default: w.burst_value = 16'($urandom_range(SMALL_BURST, 1));
      endcase
      if (pred_tok[0] == MAX_TOKENS && funded.size() == 0) begin
        w.vm_index    = 3'($urandom_range(VMS - 1, 1));
        w.burst_value = 16'($urandom_range(SMALL_BURST, 1));
      end
      if (w.burst_value > SMALL_BURST && w.vm_index != 0) trim_vm = w.vm_index;
      return w;
    end
    if (pred_tok[0] != MAX_TOKENS && holders.size() != 0 && $urandom_range(99) < 70)
      w.cur_vm = 3'(holders[$urandom_range(holders.size() - 1)]);
    if (pred_tok[0] == MAX_TOKENS && pred_tok[w.cur_vm] != 0) w.cur_vm = '0;
    after = pred_tok[0];
    if (w.cur_vm != 0 && pred_tok[w.cur_vm] != 0) after++;
    if (after == MAX_TOKENS && funded.size() != 0
        && (pred_tok[0] == MAX_TOKENS || $urandom_range(9) != 0))
      w.running_mask[funded[$urandom_range(funded.size() - 1)]] = 1'b1;
    return w;
  endfunction

  task automatic send(req_t w, bit typed = 1'b0, rsp_t want = '0);
    rsp_t got;
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    got = sched_step(w);
    pending_rsp.push_back(typed ? want : got);
  endtask

  task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // receiver with random stalls and one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result word with nothing pending: %h", rsp_word);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        cmp_field("next_vm", 16'(want.next_vm), 16'(rsp_word.next_vm));
        cmp_field("switch_count", want.switch_count, rsp_word.switch_count);
        cmp_field("reschedule", 16'(want.reschedule), 16'(rsp_word.reschedule));
        cmp_field("pool_tokens", want.pool_tokens, rsp_word.pool_tokens);
      end
    end
  end

  initial begin
    int send_idle_pct [4];
    int recv_stall_pct [4];
    send_idle_pct  = '{0, 76, 0, 17};
    recv_stall_pct = '{0, 0, 76, 17};
    for (int i = 0; i < VMS; i++) begin
      pred_tok[i] = '0;
      vm_burst[i] = '0;
    end
    pred_tok[0] = 16'(MAX_TOKENS);
    pick_vm     = '0;
    ticks_left  = '0;

    dir_rows = '{
      '{mk_tick(0, 8'h00, 8'h00), 1'b1, mk_rsp(0, 8, 1'b1, 1024)},
      '{mk_burst(1, 16'd5), 1'b1, mk_rsp(0, 8, 1'b0, 1024)},
      '{mk_burst(0, 16'hFFFF), 1'b1, mk_rsp(0, 8, 1'b0, 1024)},
      '{mk_burst(7, 16'd3), 1'b1, mk_rsp(0, 8, 1'b0, 1024)},
      '{mk_burst(2, 16'd2), 1'b1, mk_rsp(0, 8, 1'b0, 1024)},
      '{mk_burst(3, 16'd0), 1'b1, mk_rsp(0, 8, 1'b0, 1024)},
      '{mk_tick(3, 8'hFF, 8'h86), 1'b1, mk_rsp(0, 8, 1'b1, 1014)},
      '{mk_tick(0, 8'hFF, 8'hFF), 1'b1, mk_rsp(0, 7, 1'b0, 1014)},
      '{mk_tick(0, 8'h00, 8'hFF), 1'b0, '0},
      '{mk_tick(0, 8'h00, 8'hFF), 1'b0, '0},
      '{mk_tick(0, 8'h00, 8'hFF), 1'b0, '0},
      '{mk_tick(0, 8'h00, 8'hFF), 1'b0, '0},
      '{mk_tick(0, 8'h00, 8'hFF), 1'b0, '0},
      '{mk_tick(0, 8'h00, 8'hFF), 1'b0, '0},
      '{mk_tick(0, 8'h84, 8'h00), 1'b0, '0},
      '{mk_tick(2, 8'h80, 8'h00), 1'b0, '0},
      '{mk_tick(2, 8'h80, 8'h00), 1'b0, '0},
      '{mk_tick(7, 8'h06, 8'h00), 1'b0, '0},
      '{mk_tick(7, 8'h06, 8'h00), 1'b0, '0},
      '{mk_tick(7, 8'h06, 8'h00), 1'b0, '0},
      '{mk_tick(1, 8'h04, 8'h00), 1'b0, '0},
      '{mk_tick(1, 8'h04, 8'h00), 1'b0, '0},
      '{mk_tick(1, 8'h04, 8'h00), 1'b0, '0},
      '{mk_tick(1, 8'h04, 8'h00), 1'b0, '0},
      '{mk_tick(1, 8'h04, 8'hFF), 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) send(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].want);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = send_idle_pct[ph];
      recv_stall = recv_stall_pct[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 0 && n == 120) hold_req = 1'b1;
        if (ph == 1 && n == 150) begin
          req_valid <= 1'b0;
          @(posedge clk);
          while (pending_rsp.size() != 0) @(posedge clk);
        end
        send(pick_req());
      end
    end

    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/tbs_pkg.sv
design/tbs_ctrl.sv
design/tbs_datapath.sv
design/vm_token_bucket_scheduler.sv
design/tbs_checker.sv
dv/tb_vm_token_bucket_scheduler.sv
